@@ rtl/owned_relay_output_controller_unit_macros.svh @@
//------------------------------------------------------------------------------
// Owned relay output controller - assertion macros
// Clocked assertion wrappers for the controller RTL, which checks itself.
//------------------------------------------------------------------------------
`ifndef OWNED_RELAY_OUTPUT_CONTROLLER_UNIT_MACROS_SVH
`define OWNED_RELAY_OUTPUT_CONTROLLER_UNIT_MACROS_SVH

// checked only outside reset
`define ORC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ORC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/orc_pkg.sv @@
//------------------------------------------------------------------------------
// Owned relay output controller - package
// Command codes, kind codes and the per-output table entry.
//------------------------------------------------------------------------------
`default_nettype none

package orc_pkg;

   localparam logic [3:0] OP_ACTIVATE     = 4'd0;
   localparam logic [3:0] OP_DEACTIVATE   = 4'd1;
   localparam logic [3:0] OP_CLR_OWNED    = 4'd2;
   localparam logic [3:0] OP_CLR_KIND     = 4'd3;
   localparam logic [3:0] OP_TX_SET       = 4'd4;
   localparam logic [3:0] OP_TX_CLR       = 4'd5;
   localparam logic [3:0] OP_TX_CLR_ALL   = 4'd6;
   localparam logic [3:0] OP_RX_SET       = 4'd7;
   localparam logic [3:0] OP_RX_CLR       = 4'd8;
   localparam logic [3:0] OP_RX_CLR_ALL   = 4'd9;
   localparam logic [3:0] OP_PING         = 4'd10;
   localparam logic [3:0] OP_SET_SLOT     = 4'd11;
   localparam logic [3:0] OP_TXRX_ON      = 4'd12;
   localparam logic [3:0] OP_TXRX_OFF     = 4'd13;
   localparam logic [3:0] OP_PTT          = 4'd14;

   localparam logic [3:0] KIND_NONE = 4'd0;
   localparam logic [3:0] KIND_ANT  = 4'd1;

   typedef struct packed {
      logic [7:0] owner;
      logic [3:0] kind;
      logic [7:0] tx_owner;
      logic [7:0] rx_owner;
   } entry_type;

endpackage

`default_nettype wire

@@ rtl/owned_relay_output_controller_unit.sv @@
//------------------------------------------------------------------------------
// Owned relay output controller
// Relay output ownership, TX/RX combination maps and PTT driven antenna swap.
//------------------------------------------------------------------------------
// From transfer to result, every command works through the per-output table
// (owner, kind, TX and RX owner), which sits in one synchronous RAM with one
// read and one write port: every command walks all entries once, one
// read-modify-write per cycle, then the result register loads once it is
// free (empty, or its result being taken).
// A new command is taken once the result register has been loaded. After
// reset the table reads as zero at once (per-entry valid bits), no sweep.
`default_nettype none
`include "owned_relay_output_controller_unit_macros.svh"

module owned_relay_output_controller_unit #(
   parameter int NUM_OUTPUTS = 20,
   parameter int NUM_PTT     = 7
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic                   csr_wr_data,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [3:0]             req_op,
   input  wire logic [7:0]             req_from_addr,
   input  wire logic [4:0]             req_index,
   input  wire logic [2:0]             req_kind,
   input  wire logic [2:0]             req_ptt_slot,
   input  wire logic [6:0]             req_ptt_lines,
   input  wire logic                   req_last_in_message,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [NUM_OUTPUTS-1:0]      rsp_outputs_on,
   output logic [NUM_OUTPUTS-1:0]      rsp_tx_combo_on,
   output logic [NUM_OUTPUTS-1:0]      rsp_rx_combo_on,
   output logic [NUM_PTT-1:0]          rsp_ptt_leds
);
   import orc_pkg::*;

   localparam int IW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
   localparam int SW = (NUM_PTT > 1) ? $clog2(NUM_PTT) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_OUTPUTS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // table RAM
   entry_type mem [NUM_OUTPUTS];
   entry_type rd_ent_ff;
   logic      rd_vld_ff;
   logic [NUM_OUTPUTS-1:0] vld_ff;

   logic [1:0]    state_ff, state_in;
   logic [IW-1:0] iss_ff, iss_in;
   logic          iss_run_ff, iss_run_in;
   logic          stg_vld_ff;
   logic [IW-1:0] stg_idx_ff;

   logic          ptt_active_low_ff;
   logic [NUM_OUTPUTS-1:0] out_act_ff, tx_act_ff, rx_act_ff;
   logic [7:0]    slot_addr_ff [NUM_PTT];
   logic [7:0]    txrx_addr_ff [NUM_PTT];
   logic [NUM_PTT-1:0] ptt_last_ff;

   // latched command
   logic [3:0]    op_ff;
   logic [7:0]    from_ff;
   logic          ok_ff;
   logic [IW-1:0] p_ff;
   logic [3:0]    k_ff;
   logic          slot_hit_ff;
   logic          swap_ff;
   logic [7:0]    swap_addr_ff;
   logic          swap_tx_ff;

   logic                   rsp_valid_ff;
   logic [NUM_OUTPUTS-1:0] rsp_out_ff, rsp_tx_ff, rsp_rx_ff;
   logic [NUM_PTT-1:0]     rsp_leds_ff;

   logic req_fire, rsp_free, last_stage;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign last_stage = stg_vld_ff && (stg_idx_ff == LAST_IDX);

   // ---------------- decode at transfer ----------------
   logic          dec_ok;
   logic [IW-1:0] dec_p;
   logic [3:0]    dec_k;
   logic          slot_found;
   logic [SW-1:0] slot_idx;
   logic [7:0]    cur_full;
   logic [NUM_PTT-1:0] cur, diff;
   logic          diff_one;
   logic [SW-1:0] line_idx;
   logic          dec_swap;

   always_comb begin
      dec_ok = (req_index != 5'd0) && ({1'b0, req_index} <= 6'(NUM_OUTPUTS));
      dec_p  = dec_ok ? IW'(req_index - 5'd1) : '0;
      dec_k  = {1'b0, req_kind} + 4'd1;

      slot_found = 1'b0;
      slot_idx   = '0;
      for (int i = NUM_PTT - 1; i >= 0; i--) begin
         if (slot_addr_ff[i] == req_from_addr) begin
            slot_found = 1'b1;
            slot_idx   = SW'(i);
         end
      end

      cur_full = {1'b0, (ptt_active_low_ff ? ~req_ptt_lines : req_ptt_lines)};
      cur      = cur_full[NUM_PTT-1:0];
      diff     = cur ^ ptt_last_ff;
      diff_one = (diff != '0) && ((diff & (diff - 1'b1)) == '0);
      line_idx = '0;
      for (int i = 0; i < NUM_PTT; i++) begin
         if (diff[i]) line_idx = SW'(i);
      end
      dec_swap = (req_op == OP_PTT) && diff_one && (txrx_addr_ff[line_idx] != 8'd0);
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in   = state_ff;
      iss_in     = iss_ff;
      iss_run_in = iss_run_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in   = ST_WALK;
               iss_in     = '0;
               iss_run_in = 1'b1;
            end
         end
         ST_WALK: begin
            if (iss_run_ff) begin
               iss_in = iss_ff + 1'b1;
               if (iss_ff == LAST_IDX) iss_run_in = 1'b0;
            end
            if (last_stage) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         iss_ff     <= '0;
         iss_run_ff <= 1'b0;
         stg_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         iss_ff     <= iss_in;
         iss_run_ff <= iss_run_in;
         stg_vld_ff <= (state_ff == ST_WALK) && iss_run_ff;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_WALK) && iss_run_ff) begin
         rd_ent_ff  <= mem[iss_ff];
         rd_vld_ff  <= vld_ff[iss_ff];
         stg_idx_ff <= iss_ff;
      end
   end

   // ---------------- per-entry update ----------------
   entry_type e;
   logic ea, et, er, sel, own_hit;

   always_comb begin
      e  = rd_vld_ff ? rd_ent_ff : '0;
      ea = out_act_ff[stg_idx_ff];
      et = tx_act_ff[stg_idx_ff];
      er = rx_act_ff[stg_idx_ff];
      sel     = ok_ff && (stg_idx_ff == p_ff);
      own_hit = (e.owner == from_ff);
      case (op_ff)
         OP_ACTIVATE: if (sel) begin
            ea = 1'b1; e.owner = from_ff; e.kind = k_ff;
         end
         OP_DEACTIVATE: if (sel && own_hit) begin
            ea = 1'b0; e.owner = 8'd0; e.kind = KIND_NONE;
         end
         OP_CLR_OWNED: if (own_hit) begin
            ea = 1'b0; e.owner = 8'd0; e.kind = KIND_NONE;
         end
         OP_CLR_KIND: if ((e.kind == k_ff) && own_hit) begin
            ea = 1'b0; e.owner = 8'd0; e.kind = KIND_NONE;
         end
         OP_TX_SET: if (sel) begin
            et = 1'b1; e.tx_owner = from_ff;
         end
         OP_TX_CLR: if (sel) begin
            et = 1'b0; e.tx_owner = 8'd0;
         end
         OP_TX_CLR_ALL: if (e.tx_owner == from_ff) begin
            et = 1'b0; e.tx_owner = 8'd0;
         end
         OP_RX_SET: if (sel) begin
            er = 1'b1; e.rx_owner = from_ff;
            ea = 1'b1; e.owner = from_ff; e.kind = KIND_ANT;
         end
         OP_RX_CLR: if (sel) begin
            er = 1'b0; e.rx_owner = 8'd0;
            if (own_hit) begin
               ea = 1'b0; e.owner = 8'd0; e.kind = KIND_NONE;
            end
         end
         OP_RX_CLR_ALL: if (e.rx_owner == from_ff) begin
            er = 1'b0; e.rx_owner = 8'd0;
            if ((e.kind == KIND_ANT) && own_hit) begin
               ea = 1'b0; e.owner = 8'd0; e.kind = KIND_NONE;
            end
         end
         OP_TXRX_OFF: if (slot_hit_ff) begin
            et = 1'b0; er = 1'b0; e.tx_owner = 8'd0; e.rx_owner = 8'd0;
            if ((e.kind == KIND_ANT) && own_hit) begin
               ea = 1'b0; e.owner = 8'd0; e.kind = KIND_NONE;
            end
         end
         OP_PTT: if (swap_ff) begin
            // drop the owner's antennas, then raise its TX or RX combination
            if ((e.kind == KIND_ANT) && (e.owner == swap_addr_ff)) begin
               ea = 1'b0; e.owner = 8'd0; e.kind = KIND_NONE;
            end
            if ((swap_tx_ff ? e.tx_owner : e.rx_owner) == swap_addr_ff) begin
               ea = 1'b1; e.owner = swap_addr_ff; e.kind = KIND_ANT;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stg_vld_ff) mem[stg_idx_ff] <= e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_act_ff <= '0;
         tx_act_ff  <= '0;
         rx_act_ff  <= '0;
      end else if (stg_vld_ff) begin
         vld_ff[stg_idx_ff]     <= 1'b1;
         out_act_ff[stg_idx_ff] <= ea;
         tx_act_ff[stg_idx_ff]  <= et;
         rx_act_ff[stg_idx_ff]  <= er;
      end
   end

   // ---------------- command latch, slot tables, PTT ----------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff        <= req_op;
         from_ff      <= req_from_addr;
         ok_ff        <= dec_ok;
         p_ff         <= dec_p;
         k_ff         <= dec_k;
         slot_hit_ff  <= slot_found;
         swap_ff      <= dec_swap;
         swap_addr_ff <= txrx_addr_ff[line_idx];
         swap_tx_ff   <= cur[line_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptt_active_low_ff <= 1'b0;
      end else if (csr_wr_en) begin
         ptt_active_low_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptt_last_ff <= '0;
         for (int i = 0; i < NUM_PTT; i++) begin
            slot_addr_ff[i] <= 8'd0;
            txrx_addr_ff[i] <= 8'd0;
         end
      end else if (req_fire) begin
         case (req_op)
            OP_PING: begin
               if (req_ptt_slot != 3'd0) begin
                  if ({1'b0, req_ptt_slot} <= 4'(NUM_PTT))
                     slot_addr_ff[SW'(req_ptt_slot - 3'd1)] <= req_from_addr;
               end else begin
                  for (int i = 0; i < NUM_PTT; i++) begin
                     if (slot_addr_ff[i] == req_from_addr) slot_addr_ff[i] <= 8'd0;
                  end
               end
            end
            OP_SET_SLOT: begin
               if ({1'b0, req_ptt_slot} < 4'(NUM_PTT))
                  slot_addr_ff[SW'(req_ptt_slot)] <= req_from_addr;
            end
            OP_TXRX_ON:  if (slot_found) txrx_addr_ff[slot_idx] <= req_from_addr;
            OP_TXRX_OFF: if (slot_found) txrx_addr_ff[slot_idx] <= 8'd0;
            OP_PTT:      ptt_last_ff <= cur;
            default: ;
         endcase
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_out_ff  <= out_act_ff;
         rsp_tx_ff   <= tx_act_ff;
         rsp_rx_ff   <= rx_act_ff;
         rsp_leds_ff <= ptt_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outputs_on  = rsp_out_ff;
   assign rsp_tx_combo_on = rsp_tx_ff;
   assign rsp_rx_combo_on = rsp_rx_ff;
   assign rsp_ptt_leds    = rsp_leds_ff;

   // ---------------- assertions ----------------
   `ORC_ASSERT(a_fire_starts_walk, req_fire |=> (state_ff == ST_WALK) && iss_run_ff && (iss_ff == '0), "transfer did not start a table walk")
   `ORC_ASSERT(a_write_in_walk, stg_vld_ff |-> (state_ff == ST_WALK), "table write outside a walk")
   `ORC_ASSERT(a_done_loads_rsp, ((state_ff == ST_DONE) && rsp_free) |=> rsp_valid && (state_ff == ST_IDLE), "result not loaded at walk end")
   `ORC_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE) && !rsp_valid, "not idle after reset")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
//------------------------------------------------------------------------------
// Relay output controller testbench
// Drives command and PTT transfers with bursty traffic and a stalling receiver,
// predicts the output, combo and LED maps of every command, and compares each
// result transfer in order. The PTT polarity is switched between phases.
//------------------------------------------------------------------------------
`default_nettype none

module tb;
   import orc_pkg::*;

   localparam int N_OUT = 20;
   localparam int N_PTT = 7;
   localparam logic [3:0] OP_UNUSED = 4'd15;
   localparam int IDLE_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 30;
   localparam int RANDOM_ITEMS = 600;

   typedef struct {
      logic [N_OUT-1:0] on_map;
      logic [N_OUT-1:0] tx_map;
      logic [N_OUT-1:0] rx_map;
      logic [N_PTT-1:0] leds;
   } relay_maps_type;

   class relay_scoreboard;
      bit [7:0] owner[N_OUT];
      bit [3:0] kindv[N_OUT];
      bit [7:0] tx_own[N_OUT];
      bit [7:0] rx_own[N_OUT];
      bit [7:0] slot_addr[N_PTT];
      bit [7:0] txrx_addr[N_PTT];
      bit [N_OUT-1:0] on_map, tx_map, rx_map;
      bit [N_PTT-1:0] ptt_last;
      bit active_low;
      relay_maps_type expected_maps[$];
      int errors;

      function void switch_on(bit [7:0] who, int pos, bit [3:0] k);
         on_map[pos] = 1'b1;
         owner[pos] = who;
         kindv[pos] = k;
      endfunction

      function void switch_off(bit [7:0] who, int pos);
         if (owner[pos] == who) begin
            on_map[pos] = 1'b0;
            owner[pos] = 8'd0;
            kindv[pos] = KIND_NONE;
         end
      endfunction

      function int slot_of(bit [7:0] who);
         for (int i = 0; i < N_PTT; i++)
            if (slot_addr[i] == who) return i + 1;
         return 0;
      endfunction

      function void swap_antennas(int line, bit to_tx);
         bit [7:0] a;
         a = txrx_addr[line];
         if (a == 8'd0) return;
         for (int j = 0; j < N_OUT; j++) begin
            if (kindv[j] == KIND_ANT && owner[j] == a) switch_off(a, j);
            if ((to_tx ? tx_own[j] : rx_own[j]) == a) switch_on(a, j, KIND_ANT);
         end
      endfunction

      function int pending();
         return expected_maps.size();
      endfunction

      function void note_request(logic [3:0] op, logic [7:0] from, logic [4:0] idx,
                                 logic [2:0] kind, logic [2:0] slot, logic [6:0] lines);
         bit ok;
         int p, s;
         bit [3:0] k;
         bit [N_PTT-1:0] cur, diff;
         relay_maps_type r;
         ok = idx >= 1 && idx <= N_OUT;
         p = ok ? idx - 1 : 0;
         k = {1'b0, kind} + 4'd1;
         case (op)
            OP_ACTIVATE:   if (ok) switch_on(from, p, k);
            OP_DEACTIVATE: if (ok) switch_off(from, p);
            OP_CLR_OWNED:
               for (int i = 0; i < N_OUT; i++) if (owner[i] == from) switch_off(from, i);
            OP_CLR_KIND:
               for (int i = 0; i < N_OUT; i++) if (kindv[i] == k) switch_off(from, i);
            OP_TX_SET: if (ok) begin tx_map[p] = 1'b1; tx_own[p] = from; end
            OP_TX_CLR: if (ok) begin tx_map[p] = 1'b0; tx_own[p] = 8'd0; end
            OP_TX_CLR_ALL:
               for (int i = 0; i < N_OUT; i++)
                  if (tx_own[i] == from) begin tx_map[i] = 1'b0; tx_own[i] = 8'd0; end
            OP_RX_SET: if (ok) begin
               rx_map[p] = 1'b1; rx_own[p] = from;
               switch_on(from, p, KIND_ANT);
            end
            OP_RX_CLR: if (ok) begin
               rx_map[p] = 1'b0; rx_own[p] = 8'd0;
               switch_off(from, p);
            end
            OP_RX_CLR_ALL:
               for (int i = 0; i < N_OUT; i++)
                  if (rx_own[i] == from) begin
                     rx_map[i] = 1'b0; rx_own[i] = 8'd0;
                     if (kindv[i] == KIND_ANT) switch_off(from, i);
                  end
            OP_PING:
               if (slot != 0) slot_addr[slot - 1] = from;
               else
                  for (int i = 0; i < N_PTT; i++) if (slot_addr[i] == from) slot_addr[i] = 8'd0;
            OP_SET_SLOT: if (slot < N_PTT) slot_addr[slot] = from;
            OP_TXRX_ON: begin
               s = slot_of(from);
               if (s != 0) txrx_addr[s - 1] = from;
            end
            OP_TXRX_OFF: begin
               s = slot_of(from);
               if (s != 0) begin
                  txrx_addr[s - 1] = 8'd0;
                  for (int j = 0; j < N_OUT; j++) begin
                     tx_own[j] = 8'd0;
                     rx_own[j] = 8'd0;
                     if (kindv[j] == KIND_ANT) switch_off(from, j);
                  end
                  tx_map = '0;
                  rx_map = '0;
               end
            end
            OP_PTT: begin
               cur = active_low ? ~lines : lines;
               if (cur != ptt_last) begin
                  diff = cur ^ ptt_last;
                  for (int i = 0; i < N_PTT; i++)
                     if (diff == (N_PTT'(1) << i)) swap_antennas(i, cur[i]);
                  ptt_last = cur;
               end
            end
            default: ;
         endcase
         r.on_map = on_map;
         r.tx_map = tx_map;
         r.rx_map = rx_map;
         r.leds = ptt_last;
         expected_maps.push_back(r);
      endfunction

      function void check_response(relay_maps_type act);
         relay_maps_type e;
         if (expected_maps.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
            return;
         end
         e = expected_maps.pop_front();
         if (act.on_map !== e.on_map) begin
            $error("outputs_on expected %h actual %h", e.on_map, act.on_map); errors++;
         end
         if (act.tx_map !== e.tx_map) begin
            $error("tx_combo_on expected %h actual %h", e.tx_map, act.tx_map); errors++;
         end
         if (act.rx_map !== e.rx_map) begin
            $error("rx_combo_on expected %h actual %h", e.rx_map, act.rx_map); errors++;
         end
         if (act.leds !== e.leds) begin
            $error("ptt_leds expected %h actual %h", e.leds, act.leds); errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en, csr_wr_data;
   logic req_valid, req_ready;
   logic [3:0] req_op;
   logic [7:0] req_from_addr;
   logic [4:0] req_index;
   logic [2:0] req_kind, req_ptt_slot;
   logic [6:0] req_ptt_lines;
   logic req_last_in_message;
   logic rsp_valid, rsp_ready;
   logic [N_OUT-1:0] rsp_outputs_on, rsp_tx_combo_on, rsp_rx_combo_on;
   logic [N_PTT-1:0] rsp_ptt_leds;

   relay_scoreboard sb = new();
   int idle_cycles = 0;
   int burst_left = 0;
   int sent = 0;
   logic [6:0] raw_lines = '0;

   owned_relay_output_controller_unit dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_op(req_op), .req_from_addr(req_from_addr), .req_index(req_index),
      .req_kind(req_kind), .req_ptt_slot(req_ptt_slot), .req_ptt_lines(req_ptt_lines),
      .req_last_in_message(req_last_in_message),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_outputs_on(rsp_outputs_on), .rsp_tx_combo_on(rsp_tx_combo_on),
      .rsp_rx_combo_on(rsp_rx_combo_on), .rsp_ptt_leds(rsp_ptt_leds)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver stall pattern: a free-running counter sets when a new mode and pattern are drawn.
   int unsigned stall_cnt = 0;
   int unsigned stall_mode = 0;
   logic [7:0] stall_pat = 8'hff;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt % 256 == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_pat <= 8'($urandom) | 8'h01;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= stall_pat[stall_cnt % 8];
         endcase
      end
   end

   // Inputs change only at rising edges, so the negedge sees what the next edge takes.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response('{rsp_outputs_on, rsp_tx_combo_on, rsp_rx_combo_on,
                                rsp_ptt_leds});
         if (req_valid && req_ready)
            sb.note_request(req_op, req_from_addr, req_index, req_kind, req_ptt_slot,
                            req_ptt_lines);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send(logic [3:0] op, logic [7:0] from, logic [4:0] idx,
                       logic [2:0] kind, logic [2:0] slot, logic [6:0] lines);
      logic taken;
      req_valid <= 1'b1;
      req_op <= op;
      req_from_addr <= from;
      req_index <= idx;
      req_kind <= kind;
      req_ptt_slot <= slot;
      req_ptt_lines <= lines;
      req_last_in_message <= 1'($urandom_range(0, 1));
      do begin
         @(negedge clock) taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Bursty sender: random gaps between bursts of random length.
   task automatic push(logic [3:0] op, logic [7:0] from, logic [4:0] idx,
                       logic [2:0] kind, logic [2:0] slot, logic [6:0] lines);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      send(op, from, idx, kind, slot, lines);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_polarity(logic v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.active_low = v;
   endtask

   function automatic logic [7:0] pick_addr();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom);
         default: return 8'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic logic [4:0] pick_index();
      return ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, N_OUT));
   endfunction

   // PTT swap sequence: slot, TX/RX mode, combos, an activate, then mostly single-line toggles and at times TX/RX off.
   task automatic ptt_sequence();
      logic [7:0] a;
      logic [2:0] s;
      a = 8'($urandom_range(1, 4));
      s = 3'($urandom_range(0, N_PTT - 1));
      push(OP_SET_SLOT, a, pick_index(), 3'($urandom), s, 7'($urandom));
      push(OP_TXRX_ON, a, pick_index(), 3'($urandom), 3'($urandom), 7'($urandom));
      repeat ($urandom_range(1, 4))
         push(OP_TX_SET, a, pick_index(), 3'($urandom), 3'($urandom), 7'($urandom));
      repeat ($urandom_range(1, 3))
         push(OP_RX_SET, a, pick_index(), 3'($urandom), 3'($urandom), 7'($urandom));
      push(OP_ACTIVATE, a, pick_index(), 3'd0, 3'($urandom), 7'($urandom));
      repeat ($urandom_range(2, 4)) begin
         if ($urandom_range(0, 7) == 0) raw_lines = raw_lines ^ 7'($urandom);
         else raw_lines[s] = ~raw_lines[s];
         push(OP_PTT, pick_addr(), pick_index(), 3'($urandom), 3'($urandom), raw_lines);
      end
      if ($urandom_range(0, 3) == 0)
         push(OP_TXRX_OFF, a, pick_index(), 3'($urandom), 3'($urandom), 7'($urandom));
   endtask

   task automatic random_item();
      int sel;
      logic [3:0] op;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         ptt_sequence();
         return;
      end
      if (sel < 12) op = OP_PTT;
      else if (sel < 14) op = OP_UNUSED;
      else op = 4'($urandom_range(0, 14));
      if (op == OP_PTT) begin
         raw_lines = ($urandom_range(0, 1)) ? 7'($urandom) : raw_lines ^ (7'd1 << $urandom_range(0, 6));
      end
      push(op, pick_addr(), pick_index(), 3'($urandom), 3'($urandom), raw_lines);
   endtask

   initial begin
      bit held;
      held = 1'b0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 1'b0;
      req_valid <= 1'b0;
      req_op <= OP_ACTIVATE;
      req_from_addr <= '0;
      req_index <= '0;
      req_kind <= '0;
      req_ptt_slot <= '0;
      req_ptt_lines <= '0;
      req_last_in_message <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_polarity(1'b0);

      // directed: field extremes, every op, ignored indices and slots
      send(OP_ACTIVATE, 8'd255, 5'd1, 3'd7, 3'd0, 7'd0);
      send(OP_ACTIVATE, 8'd1, 5'd20, 3'd0, 3'd7, 7'h7f);
      send(OP_ACTIVATE, 8'd1, 5'd0, 3'd0, 3'd0, 7'd0);
      send(OP_ACTIVATE, 8'd1, 5'd21, 3'd0, 3'd0, 7'd0);
      send(OP_ACTIVATE, 8'd1, 5'd31, 3'd0, 3'd0, 7'd0);
      send(OP_DEACTIVATE, 8'd2, 5'd20, 3'd0, 3'd0, 7'd0);
      send(OP_DEACTIVATE, 8'd0, 5'd2, 3'd0, 3'd0, 7'd0);
      send(OP_CLR_KIND, 8'd255, 5'd0, 3'd7, 3'd0, 7'd0);
      send(OP_TX_SET, 8'd3, 5'd5, 3'd0, 3'd0, 7'd0);
      send(OP_TX_CLR, 8'd9, 5'd5, 3'd0, 3'd0, 7'd0);
      send(OP_TX_SET, 8'd3, 5'd6, 3'd0, 3'd0, 7'd0);
      send(OP_TX_CLR_ALL, 8'd3, 5'd0, 3'd0, 3'd0, 7'd0);
      send(OP_RX_SET, 8'd3, 5'd7, 3'd0, 3'd0, 7'd0);
      send(OP_RX_CLR, 8'd4, 5'd7, 3'd0, 3'd0, 7'd0);
      send(OP_RX_CLR_ALL, 8'd3, 5'd0, 3'd0, 3'd0, 7'd0);
      send(OP_PING, 8'd3, 5'd0, 3'd7, 3'd0, 7'd0);
      send(OP_PING, 8'd3, 5'd0, 3'd0, 3'd0, 7'd0);
      send(OP_SET_SLOT, 8'd3, 5'd0, 3'd0, 3'd7, 7'd0);
      send(OP_SET_SLOT, 8'd3, 5'd0, 3'd0, 3'd6, 7'd0);
      send(OP_TXRX_ON, 8'd3, 5'd0, 3'd0, 3'd0, 7'd0);
      send(OP_TX_SET, 8'd3, 5'd9, 3'd0, 3'd0, 7'd0);
      send(OP_PTT, 8'd0, 5'd0, 3'd0, 3'd0, 7'h40);
      send(OP_PTT, 8'd0, 5'd0, 3'd0, 3'd0, 7'h03);
      send(OP_TXRX_OFF, 8'd3, 5'd0, 3'd0, 3'd0, 7'd0);
      send(OP_CLR_OWNED, 8'd1, 5'd0, 3'd0, 3'd0, 7'd0);
      send(OP_UNUSED, 8'd1, 5'd1, 3'd0, 3'd0, 7'd0);
      drain();

      // random phases, polarity toggled at the start of each phase
      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         write_polarity(phase[0] ? 1'b0 : 1'b1);
         burst_left = 0;
         while (sent < (phase + 1) * (RANDOM_ITEMS / 4)) begin
            random_item();
            // sender holds off once, mid-way through the first phase, until the queue is empty
            if (!held && sent >= RANDOM_ITEMS / 8) begin
               drain();
               held = 1'b1;
            end
         end
         drain();
      end

      if (sb.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

`default_nettype wire
